// ===== hdl/lpba_pkg.sv =====
// ----------------------------------------------------------------------------
// lpba_pkg
// Types and constants shared by the link packet byte assembler.
// ----------------------------------------------------------------------------
package lpba_pkg;

  // packet lengths in data bytes
  localparam logic [3:0] ShortLen = 4'd5;
  localparam logic [3:0] LongLen  = 4'd9;

  // result status codes
  typedef enum logic [1:0] {
    ST_FAIL  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_READY = 2'd2
  } status_e;

  // one link symbol
  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_mark;
  } sym_t;

  // one result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  packet_header;
    logic [31:0] packet_key;
    logic [31:0] packet_payload;
    logic        has_payload;
  } res_t;

  // handshake pair between pipeline stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== hdl/lpba_if.sv =====
// ----------------------------------------------------------------------------
// lpba_if
// Valid/ready channels for link symbols and assembled packet results.
// ----------------------------------------------------------------------------
interface lpba_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_byte;
  logic       end_mark;

  modport source (output valid, output symbol_byte, output end_mark, input ready);
  modport sink   (input valid, input symbol_byte, input end_mark, output ready);
endinterface

interface lpba_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  packet_header;
  logic [31:0] packet_key;
  logic [31:0] packet_payload;
  logic        has_payload;

  modport source (output valid, output status, output packet_header, output packet_key,
                  output packet_payload, output has_payload, input ready);
  modport sink   (input valid, input status, input packet_header, input packet_key,
                  input packet_payload, input has_payload, output ready);
endinterface

// ===== hdl/link_packet_byte_assembler.sv =====
// ----------------------------------------------------------------------------
// link_packet_byte_assembler
// Assembles header, key and payload from link symbols, one result per symbol.
// ----------------------------------------------------------------------------
// path from symbol accept to result valid: input reg, then result reg
// one symbol per cycle unless stalled; each state update is one byte-lane write
// a stalled result holds while one more symbol waits in the input register
// reset (async, active low) clears count, resync flag, packet fields, valids
module link_packet_byte_assembler import lpba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpba_sym_if.sink    sym_i,
  lpba_res_if.source  res_o
);

  sym_t in_data, stg_sym;
  res_t stg_res, out_res;
  hs_t  in_hs, core_hs;
  logic out_ready;

  assign in_data.symbol_byte = sym_i.symbol_byte;
  assign in_data.end_mark    = sym_i.end_mark;

  // input register
  lpba_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sym_i.valid),
    .in_ready_o  (sym_i.ready),
    .in_data_i   (in_data),
    .stg_hs_o    (in_hs),
    .stg_ready_i (out_ready),
    .stg_data_o  (stg_sym)
  );

  assign core_hs.valid = in_hs.valid;
  assign core_hs.ready = in_hs.ready;

  // packet state and update
  lpba_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hs_i   (core_hs),
    .sym_i  (stg_sym),
    .res_o  (stg_res)
  );

  // result register
  lpba_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_valid_i (in_hs.valid),
    .stg_ready_o (out_ready),
    .stg_data_i  (stg_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_res)
  );

  assign res_o.status         = out_res.status;
  assign res_o.packet_header  = out_res.packet_header;
  assign res_o.packet_key     = out_res.packet_key;
  assign res_o.packet_payload = out_res.packet_payload;
  assign res_o.has_payload    = out_res.has_payload;

endmodule

// ===== hdl/lpba_in_reg.sv =====
// ----------------------------------------------------------------------------
// lpba_in_reg
// Input register: captures one link symbol, refills in the cycle it drains.
// ----------------------------------------------------------------------------
module lpba_in_reg import lpba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sym_t in_data_i,
  output hs_t  stg_hs_o,   // valid toward core, ready passed through to core
  input  logic stg_ready_i,
  output sym_t stg_data_o
);

  logic full_q, full_d;
  sym_t data_q;
  logic take;

  // accept when empty or when the held item moves on
  assign take       = full_q & stg_ready_i;
  assign in_ready_o = ~full_q | take;

  always_comb begin
    full_d = full_q;
    if (in_valid_i && in_ready_o) begin
      full_d = 1'b1;
    end else if (take) begin
      full_d = 1'b0;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // symbol register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign stg_hs_o.valid = full_q;
  assign stg_hs_o.ready = stg_ready_i;
  assign stg_data_o     = data_q;

endmodule

// ===== hdl/lpba_core.sv =====
// ----------------------------------------------------------------------------
// lpba_core
// Packet state and per-symbol update; result is formed combinationally.
// ----------------------------------------------------------------------------
module lpba_core import lpba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  hs_t  hs_i,       // valid from input register, ready from output register
  input  sym_t sym_i,
  output res_t res_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic        resync_q, resync_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [31:0] key_q, key_d;
  logic [31:0] pay_q, pay_d;
  logic [31:0] key_base, pay_base;
  logic [1:0]  key_lane, pay_lane;
  logic        adv;

  assign adv      = hs_i.valid & hs_i.ready;
  assign key_lane = 2'(cnt_q - 4'd1);
  assign pay_lane = 2'(cnt_q - ShortLen);
  // key and payload are cleared when their first byte arrives
  assign key_base = (cnt_q == 4'd1) ? '0 : key_q;
  assign pay_base = (cnt_q == ShortLen) ? '0 : pay_q;

  // next state and result for the symbol at hand
  always_comb begin
    cnt_d    = cnt_q;
    resync_d = resync_q;
    hdr_d    = hdr_q;
    key_d    = key_q;
    pay_d    = pay_q;
    res_o    = '{status: ST_BUSY, packet_header: '0, packet_key: '0,
                 packet_payload: '0, has_payload: 1'b0};
    if (sym_i.end_mark) begin
      cnt_d = '0;
      if (cnt_q == ShortLen || cnt_q == LongLen) begin
        res_o.status        = ST_READY;
        res_o.packet_header = hdr_q;
        res_o.packet_key    = key_q;
        if (cnt_q == LongLen) begin
          res_o.has_payload    = 1'b1;
          res_o.packet_payload = pay_q;
        end
      end else begin
        res_o.status = ST_FAIL;
        resync_d     = ~resync_q;
      end
    end else if (cnt_q >= LongLen) begin
      // too many data bytes
      res_o.status = ST_FAIL;
    end else begin
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd0) begin
        hdr_d = sym_i.symbol_byte;
      end else if (cnt_q < ShortLen) begin
        key_d = key_base;
        key_d[8*key_lane +: 8] = sym_i.symbol_byte;
      end else begin
        pay_d = pay_base;
        pay_d[8*pay_lane +: 8] = sym_i.symbol_byte;
      end
    end
  end

  // packet state, updated when the symbol moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      resync_q <= 1'b0;
      hdr_q    <= '0;
      key_q    <= '0;
      pay_q    <= '0;
    end else if (adv) begin
      cnt_q    <= cnt_d;
      resync_q <= resync_d;
      hdr_q    <= hdr_d;
      key_q    <= key_d;
      pay_q    <= pay_d;
    end
  end

  // byte count never passes the long packet length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LongLen)
    else $error("byte count out of range");

  // any end mark restarts the count
  a_eop_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && sym_i.end_mark |=> cnt_q == 4'd0)
    else $error("end mark did not restart count");

  // resync flag toggles exactly on a fail from a misplaced end mark
  a_resync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (resync_q != $past(resync_q)) ==
            ($past(sym_i.end_mark) && $past(res_o.status) == ST_FAIL))
    else $error("resync flag mismatch");

  // a ready result carries a payload only for a long packet
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_o.has_payload |-> res_o.status == ST_READY && cnt_q == LongLen)
    else $error("payload flag on wrong packet");

endmodule

// ===== hdl/lpba_out_reg.sv =====
// ----------------------------------------------------------------------------
// lpba_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module lpba_out_reg import lpba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic stg_valid_i,
  output logic stg_ready_o,
  input  res_t stg_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic full_q, full_d;
  res_t data_q;
  logic load;

  // load when empty or when the held result leaves this cycle
  assign stg_ready_o = ~full_q | out_ready_i;
  assign load        = stg_valid_i & stg_ready_o;

  always_comb begin
    full_d = full_q;
    if (load) begin
      full_d = 1'b1;
    end else if (out_ready_i) begin
      full_d = 1'b0;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= stg_data_i;
    end
  end

  assign out_valid_o = full_q;
  assign out_data_o  = data_q;

endmodule
